/* design/cfba_pkg.sv */
// Shared types for the contiguous first-fit block allocator.
// No dependencies; used by cfba_ctrl and the top level.
`default_nettype none

package cfba_pkg;

  // Sequencer states, one-hot coded.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_MARK = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  // Control handed from the sequencer to the ring of block cells.
  typedef struct packed {
    logic shift;     // Every cell takes its neighbor's bit.
    logic tail_bit;  // Bit that re-enters the ring at the last cell.
  } ring_ctrl_t;

  // Width of the blocks_in_use register and of the request size.
  localparam int unsigned CfgW  = 8;
  localparam int unsigned SizeW = 8;
  localparam int unsigned IdxOutW = 7;

endpackage

`default_nettype wire

/* design/cfba_cell.sv */
// One block cell of the occupancy ring: holds the occupied bit of one block.
// No dependencies.
`default_nettype none

module cfba_cell (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  shift_i,
  input  wire  occ_i,
  output logic occ_o
);

  logic occ_q;
  logic occ_d;

  // Take the neighbor's bit when the ring rotates.
  assign occ_d = shift_i ? occ_i : occ_q;

  // All blocks are free after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  assign occ_o = occ_q;

endmodule

`default_nettype wire

/* design/cfba_ctrl.sv */
// Sequencer of the allocator: runs the scan and mark passes over the ring.
// Depends on cfba_pkg.
`default_nettype none

module cfba_ctrl #(
  parameter int unsigned NUM_BLOCKS = 128
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start,
  output logic                           busy,
  input  wire  [cfba_pkg::SizeW-1:0]     request_size_i,
  input  wire  [cfba_pkg::CfgW-1:0]      blocks_in_use_i,
  input  wire                            head_i,
  output cfba_pkg::ring_ctrl_t           ring_o,
  output logic                           done_o,
  output logic                           granted_o,
  output logic [cfba_pkg::IdxOutW-1:0]   first_block_o,
  output logic [cfba_pkg::IdxOutW-1:0]   last_block_o
);

  localparam int unsigned IdxW  = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned RunW0 = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned CmpW0 = (RunW0 > cfba_pkg::SizeW) ? RunW0 : cfba_pkg::SizeW;
  localparam int unsigned CmpW  = (CmpW0 > IdxW) ? CmpW0 : IdxW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_BLOCKS - 1);

  cfba_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic [CmpW-1:0]            run_q, run_d;
  logic [cfba_pkg::SizeW-1:0] want_q, want_d;
  logic                       found_q, found_d;
  logic [IdxW-1:0]            first_q, first_d;
  logic [IdxW-1:0]            last_q, last_d;

  logic            usable;
  logic [CmpW-1:0] run_inc;
  logic            in_run;

  // Block index is inside the configured limit; idx below NUM_BLOCKS caps it.
  assign usable  = CmpW'(idx_q) < CmpW'(blocks_in_use_i);
  assign run_inc = run_q + CmpW'(1);
  assign in_run  = (idx_q >= first_q) && (idx_q <= last_q);

  // Scan and mark sequencing.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    run_d   = run_q;
    want_d  = want_q;
    found_d = found_q;
    first_d = first_q;
    last_d  = last_q;
    ring_o.shift    = 1'b0;
    ring_o.tail_bit = head_i;
    case (state_q)
      cfba_pkg::ST_IDLE: begin
        if (start) begin
          want_d  = request_size_i;
          idx_d   = '0;
          run_d   = '0;
          found_d = 1'b0;
          first_d = '0;
          last_d  = '0;
          state_d = cfba_pkg::ST_SCAN;
        end
      end
      cfba_pkg::ST_SCAN: begin
        ring_o.shift = 1'b1;
        if (!found_q && usable && (want_q != '0)) begin
          if (!head_i) begin
            run_d = run_inc;
            if (run_inc == CmpW'(want_q)) begin
              found_d = 1'b1;
              last_d  = idx_q;
              first_d = IdxW'(CmpW'(idx_q) + CmpW'(1) - CmpW'(want_q));
            end
          end else begin
            run_d = '0;
          end
        end
        idx_d = idx_q + IdxW'(1);
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = found_d ? cfba_pkg::ST_MARK : cfba_pkg::ST_RESP;
        end
      end
      cfba_pkg::ST_MARK: begin
        ring_o.shift    = 1'b1;
        ring_o.tail_bit = head_i | in_run;
        idx_d = idx_q + IdxW'(1);
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = cfba_pkg::ST_RESP;
        end
      end
      cfba_pkg::ST_RESP: begin
        state_d = cfba_pkg::ST_IDLE;
      end
      default: begin
        state_d = cfba_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfba_pkg::ST_IDLE;
      idx_q   <= '0;
      run_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      run_q   <= run_d;
      found_q <= found_d;
    end
  end

  // Request payload and run bounds.
  always_ff @(posedge clk_i) begin
    want_q  <= want_d;
    first_q <= first_d;
    last_q  <= last_d;
  end

  assign busy          = (state_q != cfba_pkg::ST_IDLE);
  assign done_o        = (state_q == cfba_pkg::ST_RESP);
  assign granted_o     = done_o & found_q;
  assign first_block_o = granted_o ? cfba_pkg::IdxOutW'(first_q) : '0;
  assign last_block_o  = granted_o ? cfba_pkg::IdxOutW'(last_q) : '0;

endmodule

`default_nettype wire

/* design/contiguous_first_fit_block_allocator_core.sv */
// Top level of the contiguous first-fit block allocator.
// Depends on cfba_pkg, cfba_cell and cfba_ctrl.
//
// Usage: drive request_size_i and raise start while busy is low; the request
// is taken at that clock edge and busy rises. The allocator looks for the
// lowest run of exactly request_size_i free blocks among blocks
// 0 .. blocks_in_use-1, marks it occupied and answers with one cycle of
// done_o carrying granted_o, first_block_o and last_block_o. A size of zero
// or a size with no fitting run is refused (granted_o low, indices zero) and
// leaves the map as it was. The receiver cannot stall: the answer is shown
// for exactly one cycle.
// A request keeps busy high until its reply is out, and busy falls in the cycle
// after done_o, with one request in flight at a time. The occupancy ring
// rotates one block past the sequencer per cycle, once to scan and, for a
// grant, once more to mark the run.
// cfg_we_i writes blocks_in_use (reset value 128). The user must raise it
// only while busy is low; the block itself does not enforce this. Reset
// frees all blocks at once; no clearing pass follows.
`default_nettype none

module contiguous_first_fit_block_allocator_core #(
  parameter int unsigned NUM_BLOCKS = 128
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [cfba_pkg::CfgW-1:0]     cfg_wdata_i,
  input  wire                           start,
  output logic                          busy,
  input  wire  [cfba_pkg::SizeW-1:0]    request_size_i,
  output logic                          done_o,
  output logic                          granted_o,
  output logic [cfba_pkg::IdxOutW-1:0]  first_block_o,
  output logic [cfba_pkg::IdxOutW-1:0]  last_block_o
);

  logic [cfba_pkg::CfgW-1:0] blocks_in_use_q;
  logic [NUM_BLOCKS-1:0]     occ;
  cfba_pkg::ring_ctrl_t      ring_ctrl;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_in_use_q <= cfba_pkg::CfgW'(128);
    end else if (cfg_we_i) begin
      blocks_in_use_q <= cfg_wdata_i;
    end
  end

  // Occupancy ring: cell 0 is the head the sequencer looks at.
  for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
    logic nb;
    if (k == NUM_BLOCKS - 1) begin : g_tail
      assign nb = ring_ctrl.tail_bit;
    end else begin : g_body
      assign nb = occ[k+1];
    end
    cfba_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ring_ctrl.shift),
      .occ_i   (nb),
      .occ_o   (occ[k])
    );
  end

  // Sequencer.
  cfba_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .request_size_i  (request_size_i),
    .blocks_in_use_i (blocks_in_use_q),
    .head_i          (occ[0]),
    .ring_o          (ring_ctrl),
    .done_o          (done_o),
    .granted_o       (granted_o),
    .first_block_o   (first_block_o),
    .last_block_o    (last_block_o)
  );

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the contiguous first-fit block allocator core.
// Depends on cfba_pkg and contiguous_first_fit_block_allocator_core; it
// predicts each reply from its own copy of the occupancy map.
`default_nettype none

module tb_top;

  localparam int unsigned NumBlocks = 128;
  localparam int unsigned MaxPrints = 30;

  // One reply of the allocator as the bench expects it.
  typedef struct packed {
    logic                          granted;
    logic [cfba_pkg::IdxOutW-1:0]  first_block;
    logic [cfba_pkg::IdxOutW-1:0]  last_block;
  } alloc_reply_t;

  // Occupancy model and store of replies still owed by the block.
  class alloc_scoreboard;
    bit           occupied [NumBlocks];
    int unsigned  blocks_in_use;
    int unsigned  used_blocks;
    int unsigned  n_requests;
    int unsigned  n_grants;
    int unsigned  n_refused;
    int unsigned  n_settings;
    int unsigned  n_mismatches;
    alloc_reply_t owed_replies[$];

    function new();
      blocks_in_use = 128;
      used_blocks = 0;
      n_requests = 0;
      n_grants = 0;
      n_refused = 0;
      n_settings = 0;
      n_mismatches = 0;
      foreach (occupied[k]) occupied[k] = 1'b0;
    endfunction

    function void set_blocks_in_use(int unsigned value);
      blocks_in_use = value;
      n_settings++;
    endfunction

    function int unsigned pending();
      return owed_replies.size();
    endfunction

    // First fit: the lowest run of free blocks that reaches the size wins.
    function void note_request(logic [cfba_pkg::SizeW-1:0] size);
      int unsigned  span;
      int unsigned  run;
      int unsigned  head;
      bit           found;
      alloc_reply_t reply;
      span = (blocks_in_use > NumBlocks) ? NumBlocks : blocks_in_use;
      run = 0;
      head = 0;
      found = 1'b0;
      reply = '0;
      if (size != 0) begin
        for (int unsigned idx = 0; idx < span && !found; idx++) begin
          if (!occupied[idx]) begin
            run++;
            if (run == size) begin
              found = 1'b1;
              head = idx + 1 - size;
              reply.last_block = idx[cfba_pkg::IdxOutW-1:0];
            end
          end else begin
            run = 0;
          end
        end
      end
      if (found) begin
        for (int unsigned k = head; k < head + size; k++) occupied[k] = 1'b1;
        used_blocks += size;
        reply.granted = 1'b1;
        reply.first_block = head[cfba_pkg::IdxOutW-1:0];
        n_grants++;
      end else begin
        n_refused++;
      end
      n_requests++;
      owed_replies.push_back(reply);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      n_mismatches++;
      if (n_mismatches <= MaxPrints) begin
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      end
    endtask

    // Compare one reply with the oldest one owed.
    task check_reply(logic granted, logic [cfba_pkg::IdxOutW-1:0] first_block,
                     logic [cfba_pkg::IdxOutW-1:0] last_block);
      alloc_reply_t want;
      if (owed_replies.size() == 0) begin
        report_mismatch("unexpected reply", 1, 0);
      end else begin
        want = owed_replies.pop_front();
        if (granted !== want.granted) report_mismatch("granted", granted, want.granted);
        if (first_block !== want.first_block) begin
          report_mismatch("first_block", first_block, want.first_block);
        end
        if (last_block !== want.last_block) begin
          report_mismatch("last_block", last_block, want.last_block);
        end
      end
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [cfba_pkg::CfgW-1:0]     cfg_wdata_i;
  logic                          start;
  logic                          busy;
  logic [cfba_pkg::SizeW-1:0]    request_size_i;
  logic                          done_o;
  logic                          granted_o;
  logic [cfba_pkg::IdxOutW-1:0]  first_block_o;
  logic [cfba_pkg::IdxOutW-1:0]  last_block_o;

  alloc_scoreboard sb = new();

  contiguous_first_fit_block_allocator_core #(
    .NUM_BLOCKS(NumBlocks)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .request_size_i (request_size_i),
    .done_o         (done_o),
    .granted_o      (granted_o),
    .first_block_o  (first_block_o),
    .last_block_o   (last_block_o)
  );

  // Clock with a period of 10.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Every reply is shown for one cycle only, so check it at that edge.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_reply(granted_o, first_block_o, last_block_o);
    end
  end

  // Present one request after an optional wait and hold it until taken.
  task issue_request(logic [cfba_pkg::SizeW-1:0] size, int unsigned gap, bit wait_idle);
    @(negedge clk_i);
    if (gap != 0 || wait_idle) begin
      start <= 1'b0;
      @(negedge clk_i);
      if (wait_idle) begin
        while (busy) @(negedge clk_i);
      end
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    request_size_i <= size;
    do @(posedge clk_i); while (busy);
    sb.note_request(size);
  endtask

  // Drop start right after the last accepted request so it is not taken twice.
  task release_start();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // The register is written only once every owed reply has come back.
  task write_blocks_in_use(logic [cfba_pkg::CfgW-1:0] value);
    release_start();
    while (sb.pending() != 0 || busy) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_blocks_in_use(value);
  endtask

  // Random idle cycles, with some requests sent back to back.
  function automatic int unsigned draw_gap(bit no_idle);
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  // Mostly small sizes so that grants spread over the run, plus zero and wide noise.
  function automatic logic [cfba_pkg::SizeW-1:0] draw_size(int unsigned span);
    int unsigned pick;
    int unsigned top;
    pick = $urandom_range(0, 99);
    top = (span == 0) ? 1 : ((span > 255) ? 255 : span);
    if (pick < 10) return '0;
    if (pick < 65) return cfba_pkg::SizeW'($urandom_range(1, 3));
    if (pick < 80) return cfba_pkg::SizeW'($urandom_range(1, top));
    return cfba_pkg::SizeW'($urandom_range(0, 255));
  endfunction

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #15_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Main sequence.
  initial begin
    int unsigned span;
    int unsigned remaining;
    bit          no_idle;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    request_size_i = '0;
    rst_ni = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset setting: zero, a single block, oversize requests.
    issue_request(8'd0, 0, 1'b0);
    issue_request(8'd1, 3, 1'b0);
    issue_request(8'd255, 0, 1'b1);
    issue_request(8'd128, 0, 1'b0);
    issue_request(8'd2, 5, 1'b1);

    // No usable block at all, then a single one that is already taken.
    write_blocks_in_use(8'd0);
    issue_request(8'd1, 0, 1'b0);
    issue_request(8'd0, 0, 1'b0);
    write_blocks_in_use(8'd1);
    issue_request(8'd1, 0, 1'b1);

    // A run that ends exactly at the limit, and one that does not fit.
    write_blocks_in_use(8'd5);
    issue_request(8'd2, 0, 1'b0);
    issue_request(8'd1, 2, 1'b0);
    write_blocks_in_use(8'd6);
    issue_request(8'd1, 0, 1'b1);

    // Random phases with a growing limit, one of them drawn over the full range.
    for (int unsigned phase = 0; phase < 8; phase++) begin
      if (phase == 7) begin
        span = 128;
      end else if (phase == 3) begin
        span = $urandom_range(0, 255);
      end else begin
        span = 6 + (phase + 1) * 15 + $urandom_range(0, 6);
      end
      write_blocks_in_use(span[cfba_pkg::CfgW-1:0]);
      no_idle = (phase % 3 == 1);
      for (int unsigned n = 0; n < 110; n++) begin
        issue_request(draw_size(span), draw_gap(no_idle), 1'($urandom_range(0, 1)));
      end
    end

    // Limit above the block count: fill up to the very last block.
    write_blocks_in_use(8'd255);
    remaining = NumBlocks - sb.used_blocks;
    if (remaining != 0) begin
      issue_request(remaining[cfba_pkg::SizeW-1:0], 0, 1'b0);
    end
    issue_request(8'd1, 0, 1'b0);
    issue_request(8'd255, 0, 1'b1);
    release_start();

    // Drain the owed replies, then watch for stray ones for a full grant latency.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2 * NumBlocks + 4) @(posedge clk_i);

    $display("Covered %0d requests (%0d granted, %0d refused) over %0d limit settings.",
             sb.n_requests, sb.n_grants, sb.n_refused, sb.n_settings);
    $display("Final occupancy %0d of %0d blocks; %0d mismatches.",
             sb.used_blocks, NumBlocks, sb.n_mismatches);
    if (sb.n_mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
